/* hw/rtl/pidarr_pkg.sv */
// ----------------------------------------------------------------------------
// pidarr_pkg
// Shared constants and types for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidarr_pkg;

    // Storage geometry
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int POS_BITS  = 8;
    localparam int KIND_BITS = 2;

    // Operation codes; any other code reads
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_ctrl_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

/* hw/rtl/positional_insert_delete_array.sv */
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Bounded ordered list of words with insert, remove and indexed read.
// ----------------------------------------------------------------------------
// Each input beat is one operation and gives exactly one result beat. An
// operation first captures the beat; then the row of entry cells shifts up
// or down in parallel and the result register is loaded. No new beat is
// taken until the previous one has executed. A new beat is accepted while
// the previous result still waits; the operation then holds until the
// result register is free. The capacity register is written through its
// own channel, always ready, and must only be written while no operation
// is in flight.
module positional_insert_delete_array (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pidarr_pkg::CNT_BITS-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [pidarr_pkg::KIND_BITS-1:0]       i_kind,
    input  logic [pidarr_pkg::POS_BITS-1:0]        i_position,
    input  logic [pidarr_pkg::WORD_BITS-1:0]       i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [1:0]                             o_status,
    output logic [pidarr_pkg::POS_BITS-1:0]        o_used_index,
    output logic [pidarr_pkg::WORD_BITS-1:0]       o_read_value,
    output logic [pidarr_pkg::CNT_BITS-1:0]        o_count
);
    import pidarr_pkg::*;

    t_dp_cmd w_cmd;

    // Configuration is taken on any cycle
    assign o_cfg_ready = 1'b1;

    // Controller
    pidarr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath
    pidarr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_status     (o_status),
        .o_used_index (o_used_index),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

endmodule

/* hw/rtl/pidarr_ctrl.sv */
// ----------------------------------------------------------------------------
// pidarr_ctrl
// Handshake controller: takes one beat at a time into the datapath, fires
// the operation once the result register is free and tracks result valid.
// ----------------------------------------------------------------------------
module pidarr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pidarr_pkg::t_dp_cmd o_cmd
);
    import pidarr_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_in_ready    = 1'b0;

        // drop the result beat once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_HOLD;
                end
            end
            S_HOLD: begin
                // run the operation when the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/pidarr_dp.sv */
// ----------------------------------------------------------------------------
// pidarr_dp
// Datapath: row of entry cells that shift up or down in parallel, entry
// count, capacity register, input capture and result register.
// ----------------------------------------------------------------------------
module pidarr_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pidarr_pkg::t_dp_cmd                    i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [pidarr_pkg::CNT_BITS-1:0]        i_cfg_data,
    input  logic [pidarr_pkg::KIND_BITS-1:0]       i_kind,
    input  logic [pidarr_pkg::POS_BITS-1:0]        i_position,
    input  logic [pidarr_pkg::WORD_BITS-1:0]       i_value,
    output logic [1:0]                             o_status,
    output logic [pidarr_pkg::POS_BITS-1:0]        o_used_index,
    output logic [pidarr_pkg::WORD_BITS-1:0]       o_read_value,
    output logic [pidarr_pkg::CNT_BITS-1:0]        o_count
);
    import pidarr_pkg::*;

    // Capacity and count
    logic [CNT_BITS-1:0]  r_capacity;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;

    // Captured operation
    logic [KIND_BITS-1:0] r_kind;
    logic [POS_BITS-1:0]  r_pos;
    logic [WORD_BITS-1:0] r_value;

    // Entry cells
    logic [WORD_BITS-1:0] r_entries [DEPTH];
    logic [WORD_BITS-1:0] n_entries [DEPTH];

    // Result register
    t_status              r_status;
    t_status              n_status;
    logic [POS_BITS-1:0]  r_used;
    logic [POS_BITS-1:0]  n_used;
    logic [WORD_BITS-1:0] r_rd;
    logic [WORD_BITS-1:0] n_rd;
    logic [CNT_BITS-1:0]  r_res_count;

    logic [CNT_BITS-1:0]  w_cap;
    logic [POS_BITS-1:0]  w_cap_ext;
    logic [POS_BITS-1:0]  w_count_ext;
    logic [IDX_BITS-1:0]  w_slot;
    logic                 w_write;

    // Limit capacity to the built depth
    assign w_cap       = (r_capacity > CNT_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : r_capacity;
    assign w_cap_ext   = POS_BITS'(w_cap);
    assign w_count_ext = POS_BITS'(r_count);

    // Decode the operation and form the shifted row
    always_comb begin
        n_status  = ST_OK;
        n_used    = r_pos;
        n_rd      = '0;
        n_count   = r_count;
        w_write   = 1'b0;
        w_slot    = r_pos[IDX_BITS-1:0];
        n_entries = r_entries;

        priority if (r_kind == KIND_INSERT) begin
            priority if (r_pos >= w_cap_ext) begin
                n_status = ST_BEYOND;
            end else if (r_count >= w_cap) begin
                n_status = ST_FULL;
            end else begin
                // append when the position is at or past the end
                if (r_pos >= w_count_ext) begin
                    n_used = w_count_ext;
                    w_slot = r_count[IDX_BITS-1:0];
                end
                w_write = 1'b1;
                n_count = r_count + 1'b1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (IDX_BITS'(i) == w_slot) begin
                        n_entries[i] = r_value;
                    end else if (i > 0 && IDX_BITS'(i) > w_slot) begin
                        n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end else if (r_kind == KIND_REMOVE) begin
            if (r_pos >= w_count_ext) begin
                n_status = ST_EMPTY;
            end else begin
                w_write = 1'b1;
                n_count = r_count - 1'b1;
                // close the gap: each cell from the slot up to the one below the top takes its upper neighbour
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (IDX_BITS'(i) >= w_slot) begin
                        n_entries[i] = r_entries[i + 1];
                    end
                end
            end
        end else begin
            if (r_pos >= w_count_ext) begin
                n_status = ST_EMPTY;
            end else begin
                n_rd = r_entries[w_slot];
            end
        end
    end

    // Control registers: capacity and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_BITS'(DEPTH);
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.execute) begin
                r_count <= n_count;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end
    end

    // Shift the entry row
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && w_write) begin
            r_entries <= n_entries;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status    <= n_status;
            r_used      <= n_used;
            r_rd        <= n_rd;
            r_res_count <= n_count;
        end
    end

    assign o_status     = r_status;
    assign o_used_index = r_used;
    assign o_read_value = r_rd;
    assign o_count      = r_res_count;

endmodule
